FILE: rtl/mds_stress_hessian_builder_unit_assert.svh
// Assertion macros for the stress Hessian builder.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef MDS_STRESS_HESSIAN_BUILDER_UNIT_ASSERT_SVH
`define MDS_STRESS_HESSIAN_BUILDER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MHB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MHB_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MHB_ASSERT(lbl, prop, msg)
`define MHB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: rtl/mhb_pkg.sv
// Types, constants and arithmetic helpers of the stress Hessian builder.
// Depends on nothing.
`default_nettype none
package mhb_pkg;
	localparam int MAX_POINTS = 64;
	localparam int MAX_DIMS   = 4;
	localparam int NBLOCKS    = MAX_DIMS * (MAX_DIMS + 1) / 2;
	localparam int NTRI       = MAX_POINTS * (MAX_POINTS + 1) / 2;
	localparam int HDEPTH     = NBLOCKS * NTRI;
	localparam int CDEPTH     = MAX_POINTS * MAX_DIMS;
	localparam int HA_W       = $clog2(HDEPTH);
	localparam int CA_W       = $clog2(CDEPTH);
	localparam int BLK_W      = $clog2(NBLOCKS + 1);
	localparam int PT_W       = 6;
	localparam int DIM_W      = 2;
	localparam int NPTS_W     = 7;
	localparam int NDIM_W     = 3;
	localparam int QUO_W      = 49;
	localparam int DCNT_W     = $clog2(QUO_W + 1);

	localparam logic [1:0] FN_LOAD  = 2'd0;
	localparam logic [1:0] FN_PAIR  = 2'd1;
	localparam logic [1:0] FN_READ  = 2'd2;
	localparam logic [1:0] FN_CLEAR = 2'd3;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_ZERO_DIST = 2'd1;
	localparam logic [1:0] STS_SELF      = 2'd2;

	localparam logic REG_POINTS = 1'b0;
	localparam logic REG_DIMS   = 1'b1;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DIVQ, S_KMUL, S_KSAT, S_DSAT, S_CRA, S_CRB, S_CDF,
		S_UDIV, S_M1, S_M1S, S_M2, S_M2S, S_OFR, S_OFW, S_DAW, S_DBW,
		S_RADR, S_RRD, S_RCAP, S_RES
	} mhb_state_t;

	function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		if (v > 34'sd2147483647) return 32'sh7fffffff;
		if (v < -34'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Product scaled by 2^-16, truncated toward zero, saturated.
	function automatic logic signed [31:0] qscale(input logic signed [65:0] p);
		logic signed [65:0] r;
		r = p[65] ? ((p + 66'sd65535) >>> 16) : (p >>> 16);
		return sat66(r);
	endfunction

	function automatic logic signed [31:0] div_sat(input logic neg,
		input logic [QUO_W-1:0] quo);
		logic signed [32:0] n;
		n = -$signed({1'b0, quo[31:0]});
		if (!neg) return (quo > QUO_W'(64'd2147483647)) ? 32'sh7fffffff : quo[31:0];
		return (quo > QUO_W'(64'd2147483648)) ? 32'sh80000000 : n[31:0];
	endfunction

	function automatic logic [HA_W-1:0] tri_off(input logic [PT_W-1:0] i,
		input logic [PT_W-1:0] j);
		logic [PT_W-1:0] hi, lo;
		logic [2*PT_W:0] prod;
		hi = (i > j) ? i : j;
		lo = (i > j) ? j : i;
		prod = (2*PT_W+1)'(hi) * (2*PT_W+1)'({1'b0, hi} + 7'd1);
		return HA_W'(prod >> 1) + HA_W'(lo);
	endfunction

	function automatic logic [HA_W-1:0] blk_base(input logic [DIM_W-1:0] s,
		input logic [DIM_W-1:0] t);
		logic [BLK_W-1:0] b;
		b = BLK_W'((BLK_W'(s) * BLK_W'({1'b0, s} + 3'd1)) >> 1) + BLK_W'(t);
		return HA_W'(b) * HA_W'(NTRI);
	endfunction

	function automatic logic [CA_W-1:0] coord_addr(input logic [PT_W-1:0] p,
		input logic [DIM_W-1:0] d);
		return CA_W'(p) * CA_W'(MAX_DIMS) + CA_W'(d);
	endfunction

	function automatic logic [NPTS_W-1:0] clamp_pts(input logic [6:0] v);
		if (v == 7'd0) return NPTS_W'(1);
		if (v > 7'(MAX_POINTS)) return NPTS_W'(MAX_POINTS);
		return v;
	endfunction

	function automatic logic [NDIM_W-1:0] clamp_dims(input logic [2:0] v);
		if (v == 3'd0) return NDIM_W'(1);
		if (v > 3'(MAX_DIMS)) return NDIM_W'(MAX_DIMS);
		return v;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/mhb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module mhb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/mds_stress_hessian_builder_unit.sv
// Top level of the stress Hessian builder: sequencer, shared divider and multiplier.
// Depends on mhb_pkg, mhb_ram and the assertion macro header.
`default_nettype none
`include "mds_stress_hessian_builder_unit_assert.svh"
// Builds the weighted stress Hessian of multidimensional scaling in signed Q16.16.
// One word is handled at a time and each word returns one result word. In a distance
// pair every quotient comes from one shared divider at one bit per cycle, one for the
// pair and one per dimension, and each of the p*(p+1)/2 blocks for p dimensions then
// uses the single port pair of the Hessian memory for one entry and two diagonals.
// A clear word and the reset each run a clearing pass over all 20800 entries of the
// Hessian memory, one entry per cycle, during which no input word is taken.
// Configuration writes are always taken and must only be issued while idle.
module mds_stress_hessian_builder_unit
	import mhb_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// func[1:0], point_a[7:2], point_b[13:8], dim_a[15:14], dim_b[17:16],
	// coord_value[49:18], weight[80:50], target_distance[111:81],
	// current_distance[142:112], zero[143]
	input  wire logic [143:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// entry[31:0], status[33:32], zero[39:34]
	output logic      [39:0]  m_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [6:0]   cfg_data
);
	mhb_state_t state_q, state_nx;

	// Input word fields.
	logic [1:0]        in_func;
	logic [PT_W-1:0]   in_a, in_b;
	logic [DIM_W-1:0]  in_da, in_db;
	logic [31:0]       in_coord;
	logic [30:0]       in_w, in_h, in_d;
	assign in_func  = s_tdata[1:0];
	assign in_a     = s_tdata[7:2];
	assign in_b     = s_tdata[13:8];
	assign in_da    = s_tdata[15:14];
	assign in_db    = s_tdata[17:16];
	assign in_coord = s_tdata[49:18];
	assign in_w     = s_tdata[80:50];
	assign in_h     = s_tdata[111:81];
	assign in_d     = s_tdata[142:112];

	logic [NPTS_W-1:0] pts_q;
	logic [NDIM_W-1:0] dims_q;
	logic              accept, a_ok, b_ok, da_ok, db_ok;

	assign accept = s_tvalid && s_tready;
	assign a_ok   = {1'b0, in_a} < pts_q;
	assign b_ok   = {1'b0, in_b} < pts_q;
	assign da_ok  = {1'b0, in_da} < dims_q;
	assign db_ok  = {1'b0, in_db} < dims_q;

	// Latched item.
	logic [PT_W-1:0]  a_q, b_q;
	logic [DIM_W-1:0] da_q, db_q;
	logic [30:0]      w_q, dvs_q;
	logic             clr_item_q;
	logic [HA_W-1:0]  clr_addr_q;

	// Pair datapath.
	logic signed [31:0] q_q, k_q, dterm_q, us_q, m1_q, val_q, ca_q;
	logic signed [31:0] u_arr [MAX_DIMS];
	logic signed [32:0] change_q;
	logic [DIM_W-1:0]   s_q, t_q;
	logic [HA_W-1:0]    tri_ab_q, tri_aa_q, tri_bb_q, base_q, haddr_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;

	// Divider.
	logic               div_load, div_neg_in, div_neg_q;
	logic [QUO_W-1:0]   div_num_in, quo_q;
	logic [30:0]        rem_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [31:0]        div_shift;
	logic [32:0]        div_diff;
	logic               div_ge;
	logic signed [31:0] div_res;

	// Memories.
	logic              cram_we, cvld_rd_q;
	logic [CA_W-1:0]   cram_waddr, cram_raddr;
	logic [31:0]       cram_rdata;
	logic signed [31:0] cdata;
	logic [CDEPTH-1:0] cvalid_q;
	logic              hram_we;
	logic [HA_W-1:0]   hram_waddr, hram_raddr;
	logic [31:0]       hram_wdata, hram_rdata;

	// Result register.
	logic              m_tvalid_q;
	logic [31:0]       res_entry_q, out_entry_q;
	logic [1:0]        res_status_q, out_status_q;
	logic              out_free;

	logic signed [33:0] neg_m2, dsub, diag_sum;
	logic signed [32:0] dfs, dfs_mag;
	logic signed [31:0] m2;

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {6'd0, out_status_q, out_entry_q};
	assign cdata     = cvld_rd_q ? $signed(cram_rdata) : 32'sd0;
	assign div_res   = div_sat(div_neg_q, quo_q);

	assign div_shift = {rem_q, quo_q[QUO_W-1]};
	assign div_diff  = {1'b0, div_shift} - {2'b00, dvs_q};
	assign div_ge    = !div_diff[32];

	assign dfs     = {ca_q[31], ca_q} - {cdata[31], cdata};
	assign dfs_mag = dfs[32] ? -dfs : dfs;
	assign m2      = qscale(prod_q);
	assign neg_m2  = -{{2{m2[31]}}, m2};
	assign dsub    = (s_q == t_q) ? {{2{dterm_q[31]}}, dterm_q} : 34'sd0;
	assign diag_sum = {{2{hram_rdata[31]}}, hram_rdata} + {change_q[32], change_q};

	mhb_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_coord_ram (
		.clk(clk), .we(cram_we), .waddr(cram_waddr), .wdata(in_coord),
		.raddr(cram_raddr), .rdata(cram_rdata)
	);

	mhb_ram #(.WIDTH(32), .DEPTH(HDEPTH)) u_hess_ram (
		.clk(clk), .we(hram_we), .waddr(hram_waddr), .wdata(hram_wdata),
		.raddr(hram_raddr), .rdata(hram_rdata)
	);

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_CLR: begin
				if (clr_addr_q == HA_W'(HDEPTH - 1)) begin
					state_nx = clr_item_q ? S_RES : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					unique case (in_func)
						FN_LOAD:  state_nx = S_RES;
						FN_PAIR:  state_nx = (in_a != in_b && in_d != '0 && a_ok && b_ok)
							? S_DIVQ : S_RES;
						FN_READ:  state_nx = (a_ok && b_ok && da_ok && db_ok) ? S_RADR : S_RES;
						FN_CLEAR: state_nx = S_CLR;
						default:  state_nx = S_RES;
					endcase
				end
			end
			S_DIVQ:  if (div_cnt_q == '0) state_nx = S_KMUL;
			S_KMUL:  state_nx = S_KSAT;
			S_KSAT:  state_nx = S_DSAT;
			S_DSAT:  state_nx = S_CRA;
			S_CRA:   state_nx = S_CRB;
			S_CRB:   state_nx = S_CDF;
			S_CDF:   state_nx = S_UDIV;
			S_UDIV:  if (div_cnt_q == '0) state_nx = S_M1;
			S_M1:    state_nx = S_M1S;
			S_M1S:   state_nx = S_M2;
			S_M2:    state_nx = S_M2S;
			S_M2S:   state_nx = S_OFR;
			S_OFR:   state_nx = S_OFW;
			S_OFW:   state_nx = S_DAW;
			S_DAW:   state_nx = S_DBW;
			S_DBW: begin
				priority if (t_q < s_q) state_nx = S_M2;
				else if (NDIM_W'(s_q) + NDIM_W'(1) < dims_q) state_nx = S_CRA;
				else state_nx = S_RES;
			end
			S_RADR:  state_nx = S_RRD;
			S_RRD:   state_nx = S_RCAP;
			S_RCAP:  state_nx = S_RES;
			S_RES:   if (out_free) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// Datapath controls.
	always_comb begin
		cram_we    = 1'b0;
		cram_waddr = coord_addr(in_a, in_da);
		cram_raddr = coord_addr(a_q, s_q);
		hram_we    = 1'b0;
		hram_waddr = clr_addr_q;
		hram_wdata = '0;
		hram_raddr = base_q + tri_ab_q;
		div_load   = 1'b0;
		div_num_in = {2'b00, in_h, 16'd0};
		div_neg_in = 1'b0;
		mul_a      = {2'b00, w_q};
		mul_b      = {q_q[31], q_q};
		unique case (state_q)
			S_CLR: begin
				hram_we = 1'b1;
			end
			S_IDLE: begin
				cram_we  = accept && in_func == FN_LOAD && a_ok && da_ok;
				div_load = accept && state_nx == S_DIVQ;
			end
			S_KSAT: mul_b = 33'sd65536 - {q_q[31], q_q};
			S_CRB:  cram_raddr = coord_addr(b_q, s_q);
			S_CDF: begin
				div_load   = 1'b1;
				div_num_in = {dfs_mag[32:0], 16'd0};
				div_neg_in = dfs[32];
			end
			S_M1: begin
				mul_a = {k_q[31], k_q};
				mul_b = {us_q[31], us_q};
			end
			S_M2: begin
				mul_a = {m1_q[31], m1_q};
				mul_b = {u_arr[t_q][31], u_arr[t_q]};
			end
			S_OFW: begin
				hram_we    = 1'b1;
				hram_waddr = base_q + tri_ab_q;
				hram_wdata = val_q;
				hram_raddr = base_q + tri_aa_q;
			end
			S_DAW: begin
				hram_we    = 1'b1;
				hram_waddr = base_q + tri_aa_q;
				hram_wdata = sat34(diag_sum);
				hram_raddr = base_q + tri_bb_q;
			end
			S_DBW: begin
				hram_we    = 1'b1;
				hram_waddr = base_q + tri_bb_q;
				hram_wdata = sat34(diag_sum);
			end
			S_RRD:  hram_raddr = haddr_q;
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_addr_q <= '0;
			clr_item_q <= 1'b0;
			cvalid_q   <= '0;
			div_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
			pts_q      <= NPTS_W'(MAX_POINTS);
			dims_q     <= NDIM_W'(MAX_DIMS);
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_POINTS) pts_q <= clamp_pts(cfg_data);
				else dims_q <= clamp_dims(cfg_data[2:0]);
			end
			if (state_q == S_CLR) clr_addr_q <= clr_addr_q + HA_W'(1);
			else clr_addr_q <= '0;
			if (state_q == S_IDLE && accept) clr_item_q <= (in_func == FN_CLEAR);
			if (cram_we) cvalid_q[cram_waddr] <= 1'b1;
			if (div_load) div_cnt_q <= DCNT_W'(QUO_W);
			else if (div_cnt_q != '0) div_cnt_q <= div_cnt_q - DCNT_W'(1);
			if (state_q == S_RES && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		prod_q    <= mul_a * mul_b;
		cvld_rd_q <= cvalid_q[cram_raddr];
		if (div_load) begin
			quo_q     <= div_num_in;
			rem_q     <= '0;
			div_neg_q <= div_neg_in;
		end else if (div_cnt_q != '0) begin
			rem_q <= div_ge ? div_diff[30:0] : div_shift[30:0];
			quo_q <= {quo_q[QUO_W-2:0], div_ge};
		end
		if (state_q == S_IDLE && accept) begin
			a_q  <= in_a;
			b_q  <= in_b;
			da_q <= in_da;
			db_q <= in_db;
			w_q  <= in_w;
			dvs_q <= in_d;
			res_entry_q <= '0;
			if (in_func == FN_PAIR && in_a == in_b) res_status_q <= STS_SELF;
			else if (in_func == FN_PAIR && in_d == '0) res_status_q <= STS_ZERO_DIST;
			else res_status_q <= STS_OK;
		end
		unique case (state_q)
			S_DIVQ: begin
				q_q      <= div_res;
				s_q      <= '0;
				tri_ab_q <= tri_off(a_q, b_q);
				tri_aa_q <= tri_off(a_q, a_q);
				tri_bb_q <= tri_off(b_q, b_q);
			end
			S_KSAT:  k_q <= qscale(prod_q);
			S_DSAT:  dterm_q <= qscale(prod_q);
			S_CRB:   ca_q <= cdata;
			S_UDIV: begin
				us_q       <= div_res;
				u_arr[s_q] <= div_res;
			end
			S_M1S: begin
				m1_q <= qscale(prod_q);
				t_q  <= '0;
			end
			S_M2:    base_q <= blk_base(s_q, t_q);
			S_M2S:   val_q <= sat34(neg_m2 - dsub);
			S_OFW:   change_q <= {hram_rdata[31], hram_rdata} - {val_q[31], val_q};
			S_DBW: begin
				if (t_q < s_q) begin
					t_q <= t_q + DIM_W'(1);
				end else begin
					s_q <= s_q + DIM_W'(1);
				end
			end
			S_RADR: haddr_q <= blk_base((da_q > db_q) ? da_q : db_q,
				(da_q > db_q) ? db_q : da_q) + tri_off(a_q, b_q);
			S_RCAP: res_entry_q <= hram_rdata;
			default: begin
			end
		endcase
		if (state_q == S_RES && out_free) begin
			out_entry_q  <= res_entry_q;
			out_status_q <= res_status_q;
		end
	end

	`MHB_ASSERT(a_div_free, div_load |-> div_cnt_q == '0, "divider loaded while busy")
	`MHB_ASSERT(a_hwr_busy, hram_we |-> state_q != S_IDLE, "Hessian write while idle")
	`MHB_ASSERT(a_t_le_s, state_q == S_M2 |-> t_q <= s_q, "block column beyond row")
	`MHB_ASSERT_RST(a_rst_quiet, !arst_n |=> !s_tready && !m_tvalid, "active in reset")
endmodule
`default_nettype wire
